// File: src/wsfd_pkg.sv
package wsfd_pkg;

  // result kinds
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // error codes
  localparam logic [1:0] ERR_PROTO   = 2'd0;
  localparam logic [1:0] ERR_PAYLOAD = 2'd1;
  localparam logic [1:0] ERR_BIG     = 2'd2;

  // opcodes
  localparam logic [3:0] OP_CONT   = 4'd0;
  localparam logic [3:0] OP_TEXT   = 4'd1;
  localparam logic [3:0] OP_BINARY = 4'd2;
  localparam logic [3:0] OP_CLOSE  = 4'd8;
  localparam logic [3:0] OP_PONG   = 4'd10;

  // 7-bit length escapes
  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_NEED_MASK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN   = 2'd1;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [3:0] opcode;
    logic       last;
    logic [1:0] error_code;
  } result_t;

endpackage

// File: src/wsfd_parser.sv
module wsfd_parser
  import wsfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [7:0]  data_byte_i,
  input  logic        need_mask_i,
  input  logic [31:0] max_frame_len_i,
  output logic        res_valid_o,
  output result_t     res_o
);

  typedef enum logic [5:0] {
    PH_HDR1  = 6'b000001,
    PH_HDR2  = 6'b000010,
    PH_EXT16 = 6'b000100,
    PH_EXT64 = 6'b001000,
    PH_KEY   = 6'b010000,
    PH_PAY   = 6'b100000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic        fin_q, fin_d;
  logic [3:0]  op_q, op_d;
  logic        masked_q, masked_d;
  logic [63:0] len_q, len_d;
  logic [3:0]  ext_q, ext_d;
  logic [31:0] key_q, key_d;
  logic [1:0]  kidx_q, kidx_d;
  logic        open_q, open_d;
  logic        halted_q, halted_d;

  // length-complete path shared by the second header byte and the extended length
  logic [63:0] ld_len;
  logic        ld_masked;
  logic [3:0]  ld_hdr;
  logic        too_big;
  logic [63:0] len_shift;
  logic [6:0]  len7;
  logic        fin_b;
  logic [3:0]  op_b;
  logic [7:0]  key_byte;
  logic [63:0] len_dec;

  assign len7      = data_byte_i[6:0];
  assign fin_b     = data_byte_i[7];
  assign op_b      = data_byte_i[3:0];
  assign len_shift = {len_q[55:0], data_byte_i};
  assign len_dec   = len_q - 64'd1;

  always_comb begin
    ld_len    = (phase_q == PH_HDR2) ? {57'd0, len7} : len_shift;
    ld_masked = (phase_q == PH_HDR2) ? data_byte_i[7] : masked_q;
    ld_hdr    = 4'd2 + ((phase_q == PH_EXT16) ? 4'd2 : (phase_q == PH_EXT64) ? 4'd8 : 4'd0)
                + (ld_masked ? 4'd4 : 4'd0);
    too_big   = ({1'b0, ld_len} + {61'd0, ld_hdr}) > {33'd0, max_frame_len_i};
  end

  always_comb begin
    unique case (kidx_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  always_comb begin
    phase_d     = phase_q;
    fin_d       = fin_q;
    op_d        = op_q;
    masked_d    = masked_q;
    len_d       = len_q;
    ext_d       = ext_q;
    key_d       = key_q;
    kidx_d      = kidx_q;
    open_d      = open_q;
    halted_d    = halted_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (!halted_q) begin
      unique case (phase_q)
        PH_HDR1: begin
          res_o.kind = KIND_ERROR;
          priority if (data_byte_i[6:4] != 3'd0) begin
            res_valid_o      = 1'b1;
            res_o.error_code = ERR_PROTO;
          end else if ((op_b > OP_BINARY && op_b < OP_CLOSE) || op_b > OP_PONG) begin
            res_valid_o      = 1'b1;
            res_o.error_code = ERR_PROTO;
          end else if (op_b == OP_TEXT) begin
            res_valid_o      = 1'b1;
            res_o.error_code = ERR_PAYLOAD;
          end else if (!fin_b && op_b != OP_CONT && op_b != OP_BINARY) begin
            res_valid_o      = 1'b1;
            res_o.error_code = ERR_PAYLOAD;
          end else if (op_b == OP_BINARY && open_q) begin
            res_valid_o      = 1'b1;
            res_o.error_code = ERR_PROTO;
          end else begin
            if (op_b == OP_CONT || op_b == OP_BINARY) begin
              open_d = !fin_b;
            end
            fin_d   = fin_b;
            op_d    = op_b;
            phase_d = PH_HDR2;
          end
          halted_d = res_valid_o;
        end
        PH_HDR2: begin
          masked_d = data_byte_i[7];
          key_d    = '0;
          if (data_byte_i[7] != need_mask_i) begin
            res_valid_o      = 1'b1;
            res_o.kind       = KIND_ERROR;
            res_o.error_code = ERR_PAYLOAD;
            halted_d         = 1'b1;
          end else if (len7 == LEN7_EXT16) begin
            len_d   = '0;
            ext_d   = 4'd2;
            phase_d = PH_EXT16;
          end else if (len7 == LEN7_EXT64) begin
            len_d   = '0;
            ext_d   = 4'd8;
            phase_d = PH_EXT64;
          end else begin
            len_d = ld_len;
            if (too_big) begin
              res_valid_o      = 1'b1;
              res_o.kind       = KIND_ERROR;
              res_o.error_code = ERR_BIG;
              halted_d         = 1'b1;
            end else if (ld_masked) begin
              kidx_d  = 2'd0;
              phase_d = PH_KEY;
            end else begin
              kidx_d = 2'd0;
              if (ld_len == 64'd0) begin
                phase_d      = PH_HDR1;
                res_valid_o  = 1'b1;
                res_o.kind   = KIND_EMPTY;
                res_o.opcode = op_q;
                res_o.last   = fin_q;
              end else begin
                phase_d = PH_PAY;
              end
            end
          end
        end
        PH_EXT16, PH_EXT64: begin
          len_d = len_shift;
          ext_d = ext_q - 4'd1;
          if (ext_d == 4'd0) begin
            if (too_big) begin
              res_valid_o      = 1'b1;
              res_o.kind       = KIND_ERROR;
              res_o.error_code = ERR_BIG;
              halted_d         = 1'b1;
            end else if (ld_masked) begin
              kidx_d  = 2'd0;
              phase_d = PH_KEY;
            end else begin
              kidx_d = 2'd0;
              if (ld_len == 64'd0) begin
                phase_d      = PH_HDR1;
                res_valid_o  = 1'b1;
                res_o.kind   = KIND_EMPTY;
                res_o.opcode = op_q;
                res_o.last   = fin_q;
              end else begin
                phase_d = PH_PAY;
              end
            end
          end
        end
        PH_KEY: begin
          key_d  = {key_q[23:0], data_byte_i};
          kidx_d = kidx_q + 2'd1;
          if (kidx_d == 2'd0) begin
            if (len_q == 64'd0) begin
              phase_d      = PH_HDR1;
              res_valid_o  = 1'b1;
              res_o.kind   = KIND_EMPTY;
              res_o.opcode = op_q;
              res_o.last   = fin_q;
            end else begin
              phase_d = PH_PAY;
            end
          end
        end
        PH_PAY: begin
          kidx_d       = kidx_q + 2'd1;
          len_d        = len_dec;
          res_valid_o  = 1'b1;
          res_o.kind   = KIND_BYTE;
          res_o.data   = data_byte_i ^ key_byte;
          res_o.opcode = op_q;
          res_o.last   = (len_dec == 64'd0) && fin_q;
          if (len_dec == 64'd0) begin
            phase_d = PH_HDR1;
          end
        end
        default: begin
          phase_d = PH_HDR1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HDR1;
      fin_q    <= 1'b0;
      op_q     <= '0;
      masked_q <= 1'b0;
      len_q    <= '0;
      ext_q    <= '0;
      key_q    <= '0;
      kidx_q   <= '0;
      open_q   <= 1'b0;
      halted_q <= 1'b0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      fin_q    <= fin_d;
      op_q     <= op_d;
      masked_q <= masked_d;
      len_q    <= len_d;
      ext_q    <= ext_d;
      key_q    <= key_d;
      kidx_q   <= kidx_d;
      open_q   <= open_d;
      halted_q <= halted_d;
    end
  end

endmodule

// File: src/wsfd_out_stage.sv
module wsfd_out_stage
  import wsfd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  logic    res_valid_i,
  input  result_t res_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_o
);

  logic    valid_q, valid_d;
  result_t res_q;
  logic    load;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign load        = in_valid_i && in_ready_o;
  assign out_valid_o = valid_q;
  assign out_o       = res_q;

  always_comb begin
    valid_d = valid_q && !out_ready_i;
    if (load) begin
      valid_d = res_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && res_valid_i) begin
      res_q <= res_i;
    end
  end

endmodule

// File: src/websocket_frame_decoder_top.sv
// websocket receive frame decoder: takes the connection stream one byte per request and
// parses frame headers (fin, rsv, opcode, mask bit, 7/16/64-bit length, 4-byte masking
// key), then hands out each payload byte unmasked, tagged with the frame opcode and a last
// flag on the final byte of a fin frame. a zero-length frame gives one empty result.
// protocol, payload and size errors give one error result, after which every byte is
// swallowed until reset. a byte is taken when the result register is free or its result
// is taken in that cycle; each byte goes through combinational header/xor logic into the
// result register, so the sustained rate is one byte per cycle while results are taken,
// and a result appears in the cycle after its byte. the user writes configuration
// (need_mask, max_frame_len) only while the block is idle; the block does not enforce this.
module websocket_frame_decoder_top
  import wsfd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_data_i,
  // byte stream in
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           data_byte_i,
  // results out
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           kind_o,
  output logic [7:0]           data_o,
  output logic [3:0]           opcode_o,
  output logic                 last_o,
  output logic [1:0]           error_code_o
);

  // configuration registers, writes to unknown indexes are dropped
  logic        need_mask_q;
  logic [31:0] max_frame_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      need_mask_q     <= 1'b1;
      max_frame_len_q <= 32'd1048576;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_NEED_MASK) begin
        need_mask_q <= cfg_data_i[0];
      end
      if (cfg_idx_i == CFG_MAX_LEN) begin
        max_frame_len_q <= cfg_data_i;
      end
    end
  end

  logic    accept;
  logic    res_valid;
  result_t res;
  result_t out_res;

  // a byte is taken whenever the result register is free or being drained
  assign accept = in_valid_i && in_ready_o;

  // header state machine, size check and payload unmasking
  wsfd_parser u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .data_byte_i     (data_byte_i),
    .need_mask_i     (need_mask_q),
    .max_frame_len_i (max_frame_len_q),
    .res_valid_o     (res_valid),
    .res_o           (res)
  );

  // result register and handshake
  wsfd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_res)
  );

  assign kind_o       = out_res.kind;
  assign data_o       = out_res.data;
  assign opcode_o     = out_res.opcode;
  assign last_o       = out_res.last;
  assign error_code_o = out_res.error_code;

endmodule
